>>> design/peaking_biquad_equalizer_bank_assert.svh
// Assertion macros for the equalizer bank.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef PEAKING_BIQUAD_EQUALIZER_BANK_ASSERT_SVH
`define PEAKING_BIQUAD_EQUALIZER_BANK_ASSERT_SVH

`ifndef ASSERT_OFF
`define PBEQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PBEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PBEQ_ASSERT(lbl, prop, msg)
`define PBEQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> design/pbeq_pkg.sv
package pbeq_pkg;

    // Configuration of the bank
    localparam int NUM_BANDS   = 8;
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 16;
    localparam int REG_COUNT   = 8;

    // Fixed port widths
    localparam int SAMPLE_IN_W  = 16;
    localparam int SAMPLE_OUT_W = 20;
    localparam int COEF_REG_W   = 64;
    localparam int COEF_SLOT_W  = 16;
    localparam int WR_INDEX_W   = 4;

    // Derived widths
    localparam int COEF_FRAC = COEF_BITS - 3;
    localparam int BAND_BITS = SAMPLE_BITS + 8;
    localparam int OUT_BITS  = SAMPLE_BITS + 4;
    localparam int DIFF_BITS = BAND_BITS + 1;
    localparam int PROD_BITS = COEF_BITS + DIFF_BITS;
    localparam int ACC_BITS  = PROD_BITS + 2;
    localparam int BAND_W    = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
    localparam int REG_W     = $clog2(REG_COUNT);
    localparam int SUM_BITS  = BAND_BITS + BAND_W;

    // Coefficient slots inside a band register
    localparam int SLOT_B0 = 0;
    localparam int SLOT_B2 = 1;
    localparam int SLOT_A1 = 2;
    localparam int SLOT_A2 = 3;

    // Input commands
    localparam logic CMD_FILTER = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // Microcode
    localparam int STEP_W = 3;

    typedef enum logic [2:0] {
        OP_MAC_B0,
        OP_MAC_D,
        OP_MAC_B2,
        OP_MAC_A2,
        OP_BAND_END,
        OP_OUT
    } op_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

    typedef struct packed {
        op_t               op;
        logic              jump_more;
        logic [STEP_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic              run;
        op_t               op;
        logic [BAND_W-1:0] band;
    } ctrl_t;

    // Program: four MAC steps and a write-back per band, loop over bands, then output
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t uc;
        uc.jump_more = 1'b0;
        uc.target    = '0;
        case (step)
            3'd0: uc.op = OP_MAC_B0;
            3'd1: uc.op = OP_MAC_D;
            3'd2: uc.op = OP_MAC_B2;
            3'd3: uc.op = OP_MAC_A2;
            3'd4:
            begin
                uc.op        = OP_BAND_END;
                uc.jump_more = 1'b1;
                uc.target    = 3'd0;
            end
            3'd5: uc.op = OP_OUT;
            default: uc.op = OP_OUT;
        endcase
        return uc;
    endfunction

endpackage

>>> design/pbeq_sample_if.sv
interface pbeq_sample_if import pbeq_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic signed [SAMPLE_IN_W-1:0] sample_in;

    modport source (output valid, output command, output sample_in, input ready);
    modport sink   (input valid, input command, input sample_in, output ready);
endinterface

>>> design/pbeq_result_if.sv
interface pbeq_result_if import pbeq_pkg::*; ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_OUT_W-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

>>> design/pbeq_sequencer.sv
module pbeq_sequencer import pbeq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  logic  stall,
    output ctrl_t ctrl
);

    seq_state_t        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [BAND_W-1:0] band_reg, band_next;
    ucode_t            uc;
    logic              last_band;

    assign uc        = ucode_rom(step_reg);
    assign last_band = (band_reg == BAND_W'(NUM_BANDS - 1));

    // State, step counter and band counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            step_reg  <= '0;
            band_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            band_reg  <= band_next;
        end
    end

    // Next step: conditional jump back while bands remain
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        band_next  = band_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (start)
                begin
                    state_next = SEQ_RUN;
                    step_next  = '0;
                    band_next  = '0;
                end
            end
            SEQ_RUN:
            begin
                if (uc.op == OP_OUT)
                begin
                    if (!stall)
                    begin
                        state_next = SEQ_IDLE;
                        step_next  = '0;
                    end
                end
                else if (uc.jump_more && !last_band)
                begin
                    step_next = uc.target;
                    band_next = band_reg + 1'b1;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    assign ctrl.run  = (state_reg == SEQ_RUN);
    assign ctrl.op   = uc.op;
    assign ctrl.band = band_reg;

endmodule

>>> design/peaking_biquad_equalizer_bank.sv
// Each accepted filter item runs the microcode: five steps per band (four MAC
// steps and a write-back) for each of the 8 bands, then one output step that
// waits while a pending result is not taken. The single MAC unit is shared by
// every band, so no new item is accepted until the program ends; a clear item
// is accepted only while idle. Reset clears all history, the coefficient registers
// and the output valid flag at once; no clearing pass is needed.
`include "peaking_biquad_equalizer_bank_assert.svh"

module peaking_biquad_equalizer_bank import pbeq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    pbeq_sample_if.sink           sample_ch,
    pbeq_result_if.source         result_ch,
    input  logic                  wr_en,
    input  logic [WR_INDEX_W-1:0] wr_index,
    input  logic [COEF_REG_W-1:0] wr_data
);

    localparam logic signed [ACC_BITS-1:0] BAND_MAX =
        {{(ACC_BITS - BAND_BITS + 1){1'b0}}, {(BAND_BITS - 1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] BAND_MIN =
        {{(ACC_BITS - BAND_BITS + 1){1'b1}}, {(BAND_BITS - 1){1'b0}}};
    localparam logic signed [SUM_BITS-1:0] OUT_MAX =
        {{(SUM_BITS - OUT_BITS + 1){1'b0}}, {(OUT_BITS - 1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] OUT_MIN =
        {{(SUM_BITS - OUT_BITS + 1){1'b1}}, {(OUT_BITS - 1){1'b0}}};
    localparam logic signed [ACC_BITS-1:0] HALF_LSB = ACC_BITS'(1) << (COEF_FRAC - 1);

    ctrl_t ctrl;
    logic  in_fire;
    logic  stall;
    logic  out_load;

    logic [COEF_REG_W-1:0]         coef_reg [REG_COUNT];
    logic signed [SAMPLE_BITS-1:0] x_reg, x1_reg, x2_reg;
    logic signed [BAND_BITS-1:0]   y1_reg [NUM_BANDS];
    logic signed [BAND_BITS-1:0]   y2_reg [NUM_BANDS];
    logic signed [ACC_BITS-1:0]    acc_reg, acc_next;
    logic signed [SUM_BITS-1:0]    sum_reg;
    logic [SAMPLE_OUT_W-1:0]       out_data_reg;
    logic                          out_valid_reg;

    logic [COEF_REG_W-1:0]         cur_coef;
    logic signed [COEF_BITS-1:0]   mult_a;
    logic signed [DIFF_BITS-1:0]   mult_b;
    logic signed [PROD_BITS-1:0]   product;
    logic signed [ACC_BITS-1:0]    rounded;
    logic signed [BAND_BITS-1:0]   y_sat;
    logic [OUT_BITS-1:0]           sum_sat;

    // Handshake
    assign in_fire         = sample_ch.valid && sample_ch.ready;
    assign sample_ch.ready = !ctrl.run;
    assign stall           = out_valid_reg && !result_ch.ready;
    assign out_load        = ctrl.run && (ctrl.op == OP_OUT) && !stall;

    pbeq_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_fire && (sample_ch.command == CMD_FILTER)),
        .stall (stall),
        .ctrl  (ctrl)
    );

    // Operand selection for the shared multiplier
    assign cur_coef = coef_reg[REG_W'(ctrl.band)];

    always_comb
    begin
        case (ctrl.op)
            OP_MAC_B0:
            begin
                mult_a = cur_coef[SLOT_B0*COEF_SLOT_W +: COEF_BITS];
                mult_b = DIFF_BITS'(x_reg);
            end
            OP_MAC_D:
            begin
                // a1 * (y1 - x1) covers the -a1 feedforward tap too
                mult_a = cur_coef[SLOT_A1*COEF_SLOT_W +: COEF_BITS];
                mult_b = DIFF_BITS'(y1_reg[ctrl.band]) - DIFF_BITS'(x1_reg);
            end
            OP_MAC_B2:
            begin
                mult_a = cur_coef[SLOT_B2*COEF_SLOT_W +: COEF_BITS];
                mult_b = DIFF_BITS'(x2_reg);
            end
            OP_MAC_A2:
            begin
                mult_a = cur_coef[SLOT_A2*COEF_SLOT_W +: COEF_BITS];
                mult_b = DIFF_BITS'(y2_reg[ctrl.band]);
            end
            default:
            begin
                mult_a = '0;
                mult_b = '0;
            end
        endcase
    end

    assign product  = mult_a * mult_b;
    assign acc_next = ((ctrl.op == OP_MAC_B0) ? ACC_BITS'(0) : acc_reg) + ACC_BITS'(product);

    // Round half up, then saturate the band result
    assign rounded = (acc_reg + HALF_LSB) >>> COEF_FRAC;

    always_comb
    begin
        if (rounded > BAND_MAX)
            y_sat = {1'b0, {(BAND_BITS - 1){1'b1}}};
        else if (rounded < BAND_MIN)
            y_sat = {1'b1, {(BAND_BITS - 1){1'b0}}};
        else
            y_sat = rounded[BAND_BITS-1:0];
    end

    // Saturate the band sum
    always_comb
    begin
        if (sum_reg > OUT_MAX)
            sum_sat = {1'b0, {(OUT_BITS - 1){1'b1}}};
        else if (sum_reg < OUT_MIN)
            sum_sat = {1'b1, {(OUT_BITS - 1){1'b0}}};
        else
            sum_sat = sum_reg[OUT_BITS-1:0];
    end

    // Coefficient registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
                coef_reg[i] <= '0;
        end
        else if (wr_en && (wr_index < WR_INDEX_W'(REG_COUNT)))
        begin
            coef_reg[wr_index[REG_W-1:0]] <= wr_data;
        end
    end

    // Filter history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg <= '0;
            x2_reg <= '0;
            for (int i = 0; i < NUM_BANDS; i++)
            begin
                y1_reg[i] <= '0;
                y2_reg[i] <= '0;
            end
        end
        else if (in_fire && (sample_ch.command == CMD_CLEAR))
        begin
            x1_reg <= '0;
            x2_reg <= '0;
            for (int i = 0; i < NUM_BANDS; i++)
            begin
                y1_reg[i] <= '0;
                y2_reg[i] <= '0;
            end
        end
        else if (ctrl.run && (ctrl.op == OP_BAND_END))
        begin
            y2_reg[ctrl.band] <= y1_reg[ctrl.band];
            y1_reg[ctrl.band] <= y_sat;
        end
        else if (out_load)
        begin
            x2_reg <= x1_reg;
            x1_reg <= x_reg;
        end
    end

    // Sample latch, accumulator and band sum
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            x_reg   <= sample_ch.sample_in[SAMPLE_BITS-1:0];
            sum_reg <= '0;
        end
        else if (ctrl.run)
        begin
            case (ctrl.op)
                OP_MAC_B0, OP_MAC_D, OP_MAC_B2, OP_MAC_A2: acc_reg <= acc_next;
                OP_BAND_END: sum_reg <= sum_reg + SUM_BITS'(y_sat);
                default: ;
            endcase
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (result_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_data_reg <= SAMPLE_OUT_W'(sum_sat);
    end

    assign result_ch.valid      = out_valid_reg;
    assign result_ch.sample_out = out_data_reg;

    // Checks
    `PBEQ_ASSERT(a_result_from_out_step, ($rose(out_valid_reg) |-> $past(out_load)), "result without output step")
    `PBEQ_ASSERT(a_no_overwrite, (out_load |-> (!out_valid_reg || result_ch.ready)), "pending result overwritten")
    `PBEQ_ASSERT_NEXT(a_clear_zeroes, in_fire && (sample_ch.command == CMD_CLEAR), (x1_reg == '0) && (x2_reg == '0) && !ctrl.run, "clear did not zero history")
    `PBEQ_ASSERT_NEXT(a_start_band0, in_fire && (sample_ch.command == CMD_FILTER), ctrl.run && (ctrl.op == OP_MAC_B0) && (ctrl.band == '0), "program did not start at band 0")

endmodule
